>>> hdl/pipc_pkg.sv
// Package for the point-in-polygon crossing test.
// Holds the vertex tally type, its saturation value and the result word type.
`default_nettype none

package pipc_pkg;

  typedef logic [1:0] tally_t;

  localparam tally_t TALLY_ONE  = 2'd1;
  localparam tally_t TALLY_FULL = 2'd3;

  typedef struct packed {
    logic inside_res;
    logic too_few_vertices;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/pipc_if.sv
// Valid/ready channel interfaces for the point-in-polygon crossing test.
// Vertex channel is sized by W; result channel carries two flag bits.
`default_nettype none

interface pipc_vtx_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] vertex_x;
  logic signed [W-1:0] vertex_y;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;
  logic                last_vertex;

  modport source (output valid, vertex_x, vertex_y, point_x, point_y, last_vertex,
                  input ready);
  modport sink   (input valid, vertex_x, vertex_y, point_x, point_y, last_vertex,
                  output ready);
endinterface

interface pipc_res_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic too_few_vertices;

  modport source (output valid, inside_res, too_few_vertices, input ready);
  modport sink   (input valid, inside_res, too_few_vertices, output ready);
endinterface

`default_nettype wire

>>> hdl/pipc_edge.sv
// One edge crossing test: differences, two products and the sign-aware
// compare, all combinational. Stands alone; no package needed.
`default_nettype none

module pipc_edge #(
  parameter int W = 16
) (
  input  wire logic                test,
  input  wire logic signed [W-1:0] xa,
  input  wire logic signed [W-1:0] ya,
  input  wire logic signed [W-1:0] xb,
  input  wire logic signed [W-1:0] yb,
  input  wire logic signed [W-1:0] px,
  input  wire logic signed [W-1:0] py,
  output logic                     toggle
);

  localparam int PW = 2 * W + 2;

  logic signed [W:0]    dpx;
  logic signed [W:0]    dpy;
  logic signed [W:0]    dx;
  logic signed [W:0]    dy;
  logic signed [PW-1:0] lhs;
  logic signed [PW-1:0] rhs;
  logic                 straddle;

  // crossing strictly right of the point: (px-xa) < (py-ya)(xb-xa)/(yb-ya)
  always_comb begin
    dpx      = $signed({px[W-1], px}) - $signed({xa[W-1], xa});
    dpy      = $signed({py[W-1], py}) - $signed({ya[W-1], ya});
    dx       = $signed({xb[W-1], xb}) - $signed({xa[W-1], xa});
    dy       = $signed({yb[W-1], yb}) - $signed({ya[W-1], ya});
    lhs      = dpx * dy;
    rhs      = dpy * dx;
    straddle = test & ((ya >= py) != (yb >= py));
    toggle   = straddle & (dy[W] ? (lhs > rhs) : (lhs < rhs));
  end

endmodule

`default_nettype wire

>>> hdl/point_in_polygon_crossing.sv
// Top level of the streamed point-in-polygon crossing test.
// Uses pipc_pkg, the pipc_vtx_if / pipc_res_if channels and pipc_edge.
`default_nettype none

// Vertices stream in one word per cycle, in cyclic order; the first word of a
// polygon also carries the query point, and the word marked last closes the
// polygon and produces one result word (inside flag, too-few-vertices flag).
// Throughput is one vertex per cycle. The result word is valid once its last
// vertex has passed the input register and then the result register, where
// the crossing parity accumulates; both edge tests (edge to the previous
// vertex and closing edge) run between the two. The vertex channel stalls
// only while a finished result waits to be taken.
module point_in_polygon_crossing
  import pipc_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  pipc_vtx_if.sink    vtx,
  pipc_res_if.source  result
);

  localparam int W = COORD_WIDTH;

  typedef struct packed {
    logic valid;
    logic last;
    logic is_first;
    logic few;
  } ctl_t;

  // polygon state
  logic signed [W-1:0] first_vx, first_vy;
  logic signed [W-1:0] prev_vx, prev_vy;
  logic signed [W-1:0] query_px, query_py;
  tally_t              vertex_tally;
  tally_t              tally_next;
  logic                awaiting_first;
  logic                crossing_parity;
  logic                parity_next;

  // stage 1
  ctl_t                s1;
  logic signed [W-1:0] s1_vx, s1_vy, s1_ax, s1_ay, s1_fx, s1_fy, s1_px, s1_py;
  logic                tog_prev, tog_close;

  res_t                res_word;
  logic                out_valid;
  logic                advance;
  logic                accept;

  assign advance   = !out_valid || result.ready;
  assign vtx.ready = advance;
  assign accept    = vtx.valid && advance;

  always_comb begin
    if (awaiting_first) begin
      tally_next = TALLY_ONE;
    end else if (vertex_tally != TALLY_FULL) begin
      tally_next = vertex_tally + TALLY_ONE;
    end else begin
      tally_next = vertex_tally;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_vx       <= '0;
      first_vy       <= '0;
      prev_vx        <= '0;
      prev_vy        <= '0;
      query_px       <= '0;
      query_py       <= '0;
      vertex_tally   <= '0;
      awaiting_first <= 1'b1;
    end else if (accept) begin
      if (awaiting_first) begin
        first_vx <= vtx.vertex_x;
        first_vy <= vtx.vertex_y;
        query_px <= vtx.point_x;
        query_py <= vtx.point_y;
      end
      prev_vx        <= vtx.vertex_x;
      prev_vy        <= vtx.vertex_y;
      vertex_tally   <= tally_next;
      awaiting_first <= vtx.last_vertex;
    end
  end

  // input register: the word plus the state it is tested against
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (advance) begin
      s1.valid    <= vtx.valid;
      s1.last     <= vtx.last_vertex;
      s1.is_first <= awaiting_first;
      s1.few      <= tally_next != TALLY_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_vx <= vtx.vertex_x;
      s1_vy <= vtx.vertex_y;
      s1_ax <= prev_vx;
      s1_ay <= prev_vy;
      s1_fx <= awaiting_first ? vtx.vertex_x : first_vx;
      s1_fy <= awaiting_first ? vtx.vertex_y : first_vy;
      s1_px <= awaiting_first ? vtx.point_x : query_px;
      s1_py <= awaiting_first ? vtx.point_y : query_py;
    end
  end

  pipc_edge #(.W(W)) u_edge_prev (
    .test   (!s1.is_first),
    .xa     (s1_ax),
    .ya     (s1_ay),
    .xb     (s1_vx),
    .yb     (s1_vy),
    .px     (s1_px),
    .py     (s1_py),
    .toggle (tog_prev)
  );

  pipc_edge #(.W(W)) u_edge_close (
    .test   (s1.last && !s1.is_first),
    .xa     (s1_vx),
    .ya     (s1_vy),
    .xb     (s1_fx),
    .yb     (s1_fy),
    .px     (s1_px),
    .py     (s1_py),
    .toggle (tog_close)
  );

  // drop the old parity when a new polygon opens
  assign parity_next = (crossing_parity && !s1.is_first) ^ tog_prev ^ tog_close;

  always_ff @(posedge clk) begin
    if (rst) begin
      crossing_parity <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (advance && s1.valid) begin
        crossing_parity <= parity_next;
      end
      if (advance) begin
        out_valid <= s1.valid && s1.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1.valid && s1.last) begin
      res_word.inside_res       <= parity_next && !s1.few;
      res_word.too_few_vertices <= s1.few;
    end
  end

  assign result.valid            = out_valid;
  assign result.inside_res       = res_word.inside_res;
  assign result.too_few_vertices = res_word.too_few_vertices;

  a_res_exclusive : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(res_word.inside_res && res_word.too_few_vertices))
    else $error("inside and too-few flags both set");

  a_stall_blocks_input : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready) |-> !vtx.ready)
    else $error("vertex taken while result stalled");

  a_last_reopens : assert property (@(posedge clk) disable iff (rst)
    (accept && vtx.last_vertex) |=> awaiting_first)
    else $error("polygon not reopened after last vertex");

  a_tally_live : assert property (@(posedge clk) disable iff (rst)
    !awaiting_first |-> (vertex_tally != '0))
    else $error("open polygon with zero vertex count");

endmodule

`default_nettype wire
